FILE: src/jsu_pkg.sv
package jsu_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;

  localparam int MaxResults = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  // All results caused by one input byte; entry 0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t [MaxResults-1:0] res;
  } batch_t;

  // Returns the digit value in bits 3:0, with bit 4 set for a non-hex byte.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

FILE: src/jsu_decode.sv
module jsu_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_i,
  input  logic [7:0]         data_i,
  input  logic               end_i,
  output jsu_pkg::batch_t    batch_o
);

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [11:0] code_acc_r, code_acc_nxt;
  logic [4:0]  hv;
  logic [15:0] code;
  jsu_pkg::batch_t b;

  assign hv   = jsu_pkg::hex_value(data_i);
  assign code = {code_acc_r, hv[3:0]};

  always_comb begin
    phase_nxt    = phase_r;
    hex_cnt_nxt  = hex_cnt_r;
    code_acc_nxt = code_acc_r;
    b            = '0;
    if (end_i) begin
      phase_nxt    = jsu_pkg::PH_IDLE;
      hex_cnt_nxt  = 2'd0;
      code_acc_nxt = 12'd0;
      b.cnt        = 2'd1;
      b.res[0]     = '{kind: jsu_pkg::KIND_ERR, data: 8'd0};
    end else begin
      case (phase_r)
        jsu_pkg::PH_IDLE: begin
          if (data_i == jsu_pkg::CH_QUOTE) begin
            phase_nxt = jsu_pkg::PH_BODY;
          end else begin
            b.cnt    = 2'd1;
            b.res[0] = '{kind: jsu_pkg::KIND_ERR, data: 8'd0};
          end
        end
        jsu_pkg::PH_BODY: begin
          if (data_i == jsu_pkg::CH_QUOTE) begin
            phase_nxt = jsu_pkg::PH_IDLE;
            b.cnt     = 2'd1;
            b.res[0]  = '{kind: jsu_pkg::KIND_END, data: 8'd0};
          end else if (data_i == jsu_pkg::CH_BSLASH) begin
            phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            b.cnt    = 2'd1;
            b.res[0] = '{kind: jsu_pkg::KIND_DATA, data: data_i};
          end
        end
        jsu_pkg::PH_ESC: begin
          phase_nxt = jsu_pkg::PH_BODY;
          b.cnt     = 2'd1;
          b.res[0].kind = jsu_pkg::KIND_DATA;
          case (data_i)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
              b.res[0].data = data_i;
            end
            jsu_pkg::CH_B: b.res[0].data = 8'h08;
            jsu_pkg::CH_F: b.res[0].data = 8'h0c;
            jsu_pkg::CH_N: b.res[0].data = 8'h0a;
            jsu_pkg::CH_R: b.res[0].data = 8'h0d;
            jsu_pkg::CH_T: b.res[0].data = 8'h09;
            jsu_pkg::CH_U: begin
              phase_nxt    = jsu_pkg::PH_HEX;
              hex_cnt_nxt  = 2'd0;
              code_acc_nxt = 12'd0;
              b            = '0;
            end
            default: begin
              phase_nxt = jsu_pkg::PH_IDLE;
              b.res[0]  = '{kind: jsu_pkg::KIND_ERR, data: 8'd0};
            end
          endcase
        end
        default: begin
          if (hv[4]) begin
            phase_nxt    = jsu_pkg::PH_IDLE;
            hex_cnt_nxt  = 2'd0;
            code_acc_nxt = 12'd0;
            b.cnt        = 2'd1;
            b.res[0]     = '{kind: jsu_pkg::KIND_ERR, data: 8'd0};
          end else if (hex_cnt_r != 2'd3) begin
            code_acc_nxt = {code_acc_r[7:0], hv[3:0]};
            hex_cnt_nxt  = hex_cnt_r + 2'd1;
          end else begin
            phase_nxt    = jsu_pkg::PH_BODY;
            hex_cnt_nxt  = 2'd0;
            code_acc_nxt = 12'd0;
            b.res[0].kind = jsu_pkg::KIND_DATA;
            b.res[1].kind = jsu_pkg::KIND_DATA;
            b.res[2].kind = jsu_pkg::KIND_DATA;
            if (code[15:7] == 9'd0) begin
              b.cnt         = 2'd1;
              b.res[0].data = {1'b0, code[6:0]};
            end else if (code[15:11] == 5'd0) begin
              b.cnt         = 2'd2;
              b.res[0].data = jsu_pkg::UTF8_LEAD2 | {3'b0, code[10:6]};
              b.res[1].data = jsu_pkg::UTF8_CONT | {2'b0, code[5:0]};
            end else begin
              b.cnt         = 2'd3;
              b.res[0].data = jsu_pkg::UTF8_LEAD3 | {4'b0, code[15:12]};
              b.res[1].data = jsu_pkg::UTF8_CONT | {2'b0, code[11:6]};
              b.res[2].data = jsu_pkg::UTF8_CONT | {2'b0, code[5:0]};
            end
          end
        end
      endcase
    end
  end

  assign batch_o = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jsu_pkg::PH_IDLE;
      hex_cnt_r  <= 2'd0;
      code_acc_r <= 12'd0;
    end else if (step_i) begin
      phase_r    <= phase_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      code_acc_r <= code_acc_nxt;
    end
  end

endmodule

FILE: src/jsu_result_buf.sv
module jsu_result_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_i,
  input  jsu_pkg::batch_t batch_i,
  output logic            free_o,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data,
  output logic            out_last
);

  jsu_pkg::res_t [jsu_pkg::MaxResults-1:0] res_r;
  logic [1:0] rem_r, rem_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign out_valid = (rem_r != 2'd0);
  assign fire      = out_valid && !out_stall;
  // A new batch may come in once the last pending result leaves.
  assign free_o    = (rem_r == 2'd0) || (rem_r == 2'd1 && fire);
  assign out_kind  = res_r[idx_r].kind;
  assign out_data  = res_r[idx_r].data;
  assign out_last  = (rem_r == 2'd1);

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load_i) begin
      rem_nxt = batch_i.cnt;
      idx_nxt = 2'd0;
    end else if (fire) begin
      rem_nxt = rem_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= batch_i.res;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, rem_r} + {1'b0, idx_r}) <= 3'd3)
    else $error("result index runs past the batch");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> (rem_r == 2'd0 || (rem_r == 2'd1 && fire)))
    else $error("batch loaded over pending results");

  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && rem_r > 2'd1) |=> (rem_r == $past(rem_r) - 2'd1))
    else $error("pending count did not step down after a transfer");

endmodule

FILE: src/json_string_unescape_utf8.sv
// Decodes a JSON string literal fed one byte per transfer, starting with the
// opening quote, into its raw bytes, with \u escapes turned into one to three
// UTF-8 bytes; a closing quote gives an end result and any fault an error
// result. Input bytes are taken at one per cycle unless in_stall is high. Each
// byte is registered, decoded from that register and its results loaded into a
// three-entry result buffer once it is free; the buffer sends one result per
// cycle unless out_stall is high. A byte that yields two or three results (a \u
// escape of 0x80 or above) holds the input until its results have drained.
module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_last
);

  logic            s1_valid_r, s1_valid_nxt;
  logic [7:0]      s1_data_r;
  logic            s1_end_r;
  logic            buf_free;
  logic            step;
  jsu_pkg::batch_t batch;

  assign step     = s1_valid_r && buf_free;
  assign in_stall = s1_valid_r && !buf_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data_byte;
      s1_end_r  <= in_text_end;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .data_i  (s1_data_r),
    .end_i   (s1_end_r),
    .batch_o (batch)
  );

  jsu_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (step),
    .batch_i   (batch),
    .free_o    (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_data  (out_out_byte),
    .out_last  (out_last)
  );

endmodule

FILE: tb/sv/json_string_unescape_utf8_test.sv
`timescale 1ns / 100ps

module json_string_unescape_utf8_test;

  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LETTER_Q = 8'h71;
  localparam logic [7:0] CH_LETTER_G = 8'h67;
  localparam logic [7:0] CH_OPEN_BRACE = 8'h7b;

  localparam logic [7:0] CTL_BACKSPACE = 8'h08;
  localparam logic [7:0] CTL_FORMFEED  = 8'h0c;
  localparam logic [7:0] CTL_NEWLINE   = 8'h0a;
  localparam logic [7:0] CTL_RETURN    = 8'h0d;
  localparam logic [7:0] CTL_TAB       = 8'h09;

  localparam int RandomItems = 300;
  localparam int DrainCycles = 20;
  localparam int LimitNs     = 4_000_000;
  localparam int LowIdlePct  = 9;
  localparam int HighIdlePct = 59;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       text_end;
  } text_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_text_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic       out_last;

  json_string_unescape_utf8 u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_text_end  (in_text_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

  always #10 clk = ~clk;

  text_item_t pending_q[$];
  decoded_t   unescaped_q[$];
  decoded_t   step_q[$];

  int total_items = 0;
  int accepted_count = 0;
  int loaded_count = 0;
  int hold_at_a = -1;
  int hold_at_b = -1;
  int fail_count = 0;

  // Decoder state as the predictor sees it.
  logic [1:0]  dec_phase = jsu_pkg::PH_IDLE;
  logic [1:0]  dec_hex_count = 2'd0;
  logic [11:0] dec_code_acc = 12'h000;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) return {1'b0, 4'(c - CH_DIGIT0)};
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
    if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic is_escape_letter(input logic [7:0] c);
    return c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH || c == jsu_pkg::CH_SLASH ||
           c == jsu_pkg::CH_B || c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
           c == jsu_pkg::CH_R || c == jsu_pkg::CH_T || c == jsu_pkg::CH_U;
  endfunction

  task automatic emit(input logic [1:0] kind, input logic [7:0] data);
    decoded_t r;
    r.kind = kind;
    r.data = data;
    r.last = 1'b0;
    step_q.insert(step_q.size(), r);
  endtask

  task automatic decode_fault();
    dec_phase = jsu_pkg::PH_IDLE;
    dec_hex_count = 2'd0;
    dec_code_acc = 12'h000;
    emit(jsu_pkg::KIND_ERR, 8'h00);
  endtask

  task automatic unescape_byte(input logic [7:0] c, input logic ended);
    logic [4:0]  v;
    logic [15:0] unit;
    decoded_t    r;
    step_q.delete();
    if (ended) begin
      decode_fault();
    end else begin
      case (dec_phase)
        jsu_pkg::PH_IDLE: begin
          if (c == jsu_pkg::CH_QUOTE) dec_phase = jsu_pkg::PH_BODY;
          else decode_fault();
        end
        jsu_pkg::PH_BODY: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            dec_phase = jsu_pkg::PH_IDLE;
            emit(jsu_pkg::KIND_END, 8'h00);
          end else if (c == jsu_pkg::CH_BSLASH) begin
            dec_phase = jsu_pkg::PH_ESC;
          end else begin
            emit(jsu_pkg::KIND_DATA, c);
          end
        end
        jsu_pkg::PH_ESC: begin
          dec_phase = jsu_pkg::PH_BODY;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              emit(jsu_pkg::KIND_DATA, c);
            jsu_pkg::CH_B: emit(jsu_pkg::KIND_DATA, CTL_BACKSPACE);
            jsu_pkg::CH_F: emit(jsu_pkg::KIND_DATA, CTL_FORMFEED);
            jsu_pkg::CH_N: emit(jsu_pkg::KIND_DATA, CTL_NEWLINE);
            jsu_pkg::CH_R: emit(jsu_pkg::KIND_DATA, CTL_RETURN);
            jsu_pkg::CH_T: emit(jsu_pkg::KIND_DATA, CTL_TAB);
            jsu_pkg::CH_U: begin
              dec_phase = jsu_pkg::PH_HEX;
              dec_hex_count = 2'd0;
              dec_code_acc = 12'h000;
            end
            default: decode_fault();
          endcase
        end
        default: begin
          v = digit_value(c);
          if (v[4]) begin
            decode_fault();
          end else if (dec_hex_count < 2'd3) begin
            dec_code_acc = {dec_code_acc[7:0], v[3:0]};
            dec_hex_count = dec_hex_count + 2'd1;
          end else begin
            unit = {dec_code_acc, v[3:0]};
            dec_phase = jsu_pkg::PH_BODY;
            dec_hex_count = 2'd0;
            dec_code_acc = 12'h000;
            if (unit < 16'h0080) begin
              emit(jsu_pkg::KIND_DATA, unit[7:0]);
            end else if (unit < 16'h0800) begin
              emit(jsu_pkg::KIND_DATA, jsu_pkg::UTF8_LEAD2 | {3'b000, unit[10:6]});
              emit(jsu_pkg::KIND_DATA, jsu_pkg::UTF8_CONT | {2'b00, unit[5:0]});
            end else begin
              emit(jsu_pkg::KIND_DATA, jsu_pkg::UTF8_LEAD3 | {4'h0, unit[15:12]});
              emit(jsu_pkg::KIND_DATA, jsu_pkg::UTF8_CONT | {2'b00, unit[11:6]});
              emit(jsu_pkg::KIND_DATA, jsu_pkg::UTF8_CONT | {2'b00, unit[5:0]});
            end
          end
        end
      endcase
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.insert(step_q.size(), r);
    end
    while (step_q.size() > 0) unescaped_q.insert(unescaped_q.size(), step_q.pop_front());
  endtask

  function automatic int sender_idle_pct(input int done);
    if (done < total_items / 3) return LowIdlePct;
    if (done < 2 * total_items / 3) return HighIdlePct;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(input int done);
    if (done < total_items / 3) return HighIdlePct;
    if (done < 2 * total_items / 3) return LowIdlePct;
    return 0;
  endfunction

  // Driver: account for the transfer that just happened, then present the next item.
  text_item_t next_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'h00;
      in_text_end <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        unescape_byte(in_data_byte, in_text_end);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 &&
            !((loaded_count == hold_at_a || loaded_count == hold_at_b) &&
              unescaped_q.size() != 0) &&
            $urandom_range(0, 99) >= sender_idle_pct(accepted_count)) begin
          next_item = pending_q.pop_front();
          loaded_count++;
          in_valid <= 1'b1;
          in_data_byte <= next_item.data_byte;
          in_text_end <= next_item.text_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction.
  decoded_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (unescaped_q.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte 0x%02h, last %0d",
                 out_kind, out_out_byte, out_last);
          fail_count++;
        end else begin
          want = unescaped_q.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_out_byte !== want.data) begin
            $error("out_byte mismatch: expected 0x%02h, actual 0x%02h", want.data, out_out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct(accepted_count));
    end
  end

  task automatic add_item(input logic [7:0] b, input logic ended);
    text_item_t t;
    t.data_byte = b;
    t.text_end = ended;
    pending_q.insert(pending_q.size(), t);
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_item(b, 1'b0);
  endtask

  // The byte that rides along with an end-of-text marker is random and must be ignored.
  task automatic add_end();
    add_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_DIGIT0 + 8'(v);
    if ($urandom_range(0, 1) == 0) return CH_LOWER_A + 8'(v - 4'd10);
    return CH_UPPER_A + 8'(v - 4'd10);
  endfunction

  task automatic add_unit(input logic [15:0] unit);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte(hex_char(unit[15:12]));
    add_byte(hex_char(unit[11:8]));
    add_byte(hex_char(unit[7:4]));
    add_byte(hex_char(unit[3:0]));
  endtask

  task automatic add_segment();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      b = 8'($urandom);
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH) b = 8'($urandom);
      add_byte(b);
    end else if (pick < 7) begin
      add_byte(jsu_pkg::CH_BSLASH);
      case ($urandom_range(0, 7))
        0: add_byte(jsu_pkg::CH_QUOTE);
        1: add_byte(jsu_pkg::CH_BSLASH);
        2: add_byte(jsu_pkg::CH_SLASH);
        3: add_byte(jsu_pkg::CH_B);
        4: add_byte(jsu_pkg::CH_F);
        5: add_byte(jsu_pkg::CH_N);
        6: add_byte(jsu_pkg::CH_R);
        default: add_byte(jsu_pkg::CH_T);
      endcase
    end else begin
      // Spread code units over the one-, two- and three-byte encodings.
      case ($urandom_range(0, 2))
        0: add_unit(16'($urandom_range(16'h0000, 16'h007f)));
        1: add_unit(16'($urandom_range(16'h0080, 16'h07ff)));
        default: add_unit(16'($urandom_range(16'h0800, 16'hffff)));
      endcase
    end
  endtask

  task automatic add_good_string();
    int n;
    add_byte(jsu_pkg::CH_QUOTE);
    n = $urandom_range(0, 8);
    repeat (n) add_segment();
    add_byte(jsu_pkg::CH_QUOTE);
  endtask

  task automatic add_broken_string();
    int         mode;
    int         n;
    logic [7:0] b;
    mode = $urandom_range(0, 3);
    if (mode == 0) begin
      // Noise while no string is open.
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          add_end();
        end else begin
          b = 8'($urandom);
          while (b == jsu_pkg::CH_QUOTE) b = 8'($urandom);
          add_byte(b);
        end
      end
    end else begin
      add_byte(jsu_pkg::CH_QUOTE);
      n = $urandom_range(0, 3);
      repeat (n) add_segment();
      if (mode == 1) begin
        // Text runs out in the body, after a backslash, or among hex digits.
        case ($urandom_range(0, 2))
          0: ;
          1: add_byte(jsu_pkg::CH_BSLASH);
          default: begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(jsu_pkg::CH_U);
            n = $urandom_range(0, 3);
            repeat (n) add_byte(hex_char(4'($urandom)));
          end
        endcase
        add_end();
      end else if (mode == 2) begin
        add_byte(jsu_pkg::CH_BSLASH);
        b = 8'($urandom);
        while (is_escape_letter(b)) b = 8'($urandom);
        add_byte(b);
      end else begin
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_U);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(hex_char(4'($urandom)));
        b = 8'($urandom);
        while (digit_value(b) != 5'h10) b = 8'($urandom);
        add_byte(b);
      end
    end
  endtask

  initial begin
    int directed_count;

    // Faults in idle, raw extremes, simple escapes, the zero unit and all encoding sizes.
    add_end();
    add_byte(CH_OPEN_BRACE);
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(8'h00);
    add_byte(8'hff);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_T);
    add_unit(16'h0000);
    add_unit(16'h07ab);
    add_unit(16'hffff);
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(CH_LETTER_Q);
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte(CH_DIGIT0);
    add_byte(CH_LETTER_G);
    add_byte(jsu_pkg::CH_QUOTE);
    add_end();
    directed_count = pending_q.size();

    while (pending_q.size() < directed_count + RandomItems) begin
      if ($urandom_range(0, 99) < 80) add_good_string();
      else add_broken_string();
    end
    total_items = pending_q.size();
    hold_at_a = directed_count;
    hold_at_b = directed_count + RandomItems / 2;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (unescaped_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && unescaped_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
src/jsu_pkg.sv
src/jsu_decode.sv
src/jsu_result_buf.sv
src/json_string_unescape_utf8.sv
tb/sv/json_string_unescape_utf8_test.sv
